### hw/rtl/hdc_pkg.sv
// shared types and constants for the humidifier duty controller
`timescale 1ns / 1ps
`default_nettype none

package hdc_pkg;

    localparam int LEVEL_W   = 10;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 10;
    localparam int PROD_W    = 21;
    localparam int MAG_W     = 20;

    localparam int unsigned OFF_DELAY_MS_DEF = 300000;
    localparam int unsigned DEADBAND_DEF     = 7;

    localparam logic [LEVEL_W-1:0] FAN_FULL_SCALE = 10'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX      = 10'd1023;
    localparam logic [LEVEL_W-1:0] READING_LIMIT  = 10'd1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DESIRED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATOM_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATOM_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_IDLE = 3'd5;

    typedef struct packed {
        logic [LEVEL_W-1:0] humidity_reading;
        logic               water_low;
        logic [TIME_W-1:0]  now_ms;
    } hdc_in_t;

    typedef struct packed {
        logic               valve_open;
        logic [LEVEL_W-1:0] atomizer_duty;
        logic [LEVEL_W-1:0] fan_duty;
        logic               water_low_seen;
        logic               reading_invalid;
    } hdc_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic fan_phase;
        logic div_start;
        logic atom_apply;
        logic fan_apply;
    } hdc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } hdc_sts_t;

endpackage

`default_nettype wire

### hw/rtl/hdc_div.sv
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module hdc_div
    import hdc_pkg::*;
#(
    parameter int DVD_W = MAG_W,
    parameter int DVS_W = LEVEL_W
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hw/rtl/hdc_dp.sv
// datapath: registers, shared multiplier, atomizer divider, duty update logic
`timescale 1ns / 1ps
`default_nettype none

module hdc_dp
    import hdc_pkg::*;
#(
    parameter int unsigned OFF_DELAY_MS = OFF_DELAY_MS_DEF,
    parameter int unsigned DEADBAND     = DEADBAND_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hdc_cmd_t             cmd,
    output hdc_sts_t                  sts,
    input  wire hdc_in_t              in_data,
    output hdc_out_t                  out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam logic [LEVEL_W-1:0] DEADBAND_L  = LEVEL_W'(DEADBAND);
    localparam logic [TIME_W-1:0]  OFF_DELAY_L = TIME_W'(OFF_DELAY_MS);

    // divide by 1000 as multiply by ceil(2^30 / 1000) then shift by 30,
    // exact for every magnitude below 2^20
    localparam int                  RECIP_W     = 21;
    localparam int                  RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0]  FAN_RECIP   = 21'd1073742;

    typedef enum logic [1:0] {
        ATOM_ZERO   = 2'd0,
        ATOM_MAX    = 2'd1,
        ATOM_MIN    = 2'd2,
        ATOM_INTERP = 2'd3
    } atom_sel_t;

    // configuration
    logic [LEVEL_W-1:0] desired_reg, low_reg, atom_max_reg, atom_min_reg;
    logic [LEVEL_W-1:0] fan_high_reg, fan_idle_reg;

    // tick state
    logic [LEVEL_W-1:0] atom_level_reg, atom_level_next;
    logic [LEVEL_W-1:0] fan_level_reg, fan_level_next;
    logic [TIME_W-1:0]  last_active_reg;
    logic               valve_reg, wl_reg, invalid_reg;

    // per-beat working registers
    logic [LEVEL_W-1:0]       h_reg;
    logic [TIME_W-1:0]        now_reg;
    atom_sel_t                sel_reg, sel_next;
    logic signed [PROD_W-1:0] prod_reg;
    hdc_out_t                 out_reg;
    logic [MAG_W-1:0]         fan_q_reg;
    logic                     fan_done_reg;

    logic                     invalid_in;
    logic signed [LEVEL_W:0]  mul_a;
    logic [LEVEL_W-1:0]       mul_b;
    logic signed [PROD_W:0]   prod_full;
    logic [PROD_W-1:0]        prod_abs;
    logic [MAG_W-1:0]         div_quotient;
    logic                     div_done;
    logic [MAG_W+RECIP_W-1:0] fan_recip_prod;
    logic [MAG_W-1:0]         quotient;
    logic signed [PROD_W:0]   q_signed;
    logic signed [PROD_W:0]   interp_sum;
    logic [LEVEL_W-1:0]       interp;
    logic [LEVEL_W-1:0]       base;
    logic [LEVEL_W-1:0]       atom_new, fan_new;
    logic                     fan_off;

    function automatic logic [LEVEL_W-1:0] abs_diff(
        input logic [LEVEL_W-1:0] a,
        input logic [LEVEL_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desired_reg  <= 10'd500;
            low_reg      <= 10'd300;
            atom_max_reg <= 10'd1000;
            atom_min_reg <= 10'd0;
            fan_high_reg <= 10'd1000;
            fan_idle_reg <= 10'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DESIRED:  desired_reg  <= cfg_data;
                REG_LOW:      low_reg      <= cfg_data;
                REG_ATOM_MAX: atom_max_reg <= cfg_data;
                REG_ATOM_MIN: atom_min_reg <= cfg_data;
                REG_FAN_HIGH: fan_high_reg <= cfg_data;
                REG_FAN_IDLE: fan_idle_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // early decisions on the incoming reading
    assign invalid_in = (in_data.humidity_reading == '0)
                     || (in_data.humidity_reading >= READING_LIMIT);

    always_comb
    begin
        if (invalid_in || (in_data.humidity_reading > desired_reg))
        begin
            sel_next = ATOM_ZERO;
        end
        else if (in_data.humidity_reading < low_reg)
        begin
            sel_next = ATOM_MAX;
        end
        else if (low_reg == desired_reg)
        begin
            sel_next = ATOM_MIN;
        end
        else
        begin
            sel_next = ATOM_INTERP;
        end
    end

    // shared multiplier: duty span times humidity distance, or fan span times level
    always_comb
    begin
        if (cmd.fan_phase)
        begin
            mul_a = $signed({1'b0, fan_high_reg}) - $signed({1'b0, fan_idle_reg});
            mul_b = atom_level_reg;
            base  = fan_idle_reg;
        end
        else
        begin
            mul_a = $signed({1'b0, atom_max_reg}) - $signed({1'b0, atom_min_reg});
            mul_b = desired_reg - h_reg;
            base  = atom_min_reg;
        end
    end

    assign prod_full = mul_a * $signed({1'b0, mul_b});
    assign prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // divider only serves the atomizer span
    hdc_div #(
        .DVD_W (MAG_W),
        .DVS_W (LEVEL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start && !cmd.fan_phase),
        .dividend (prod_abs[MAG_W-1:0]),
        .divisor  (desired_reg - low_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // fan scaling by 1000: reciprocal multiply, registered on the start command
    assign fan_recip_prod = (MAG_W + RECIP_W)'(prod_abs[MAG_W-1:0])
                          * (MAG_W + RECIP_W)'(FAN_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_done_reg <= 1'b0;
        end
        else
        begin
            fan_done_reg <= cmd.div_start && cmd.fan_phase;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start && cmd.fan_phase)
        begin
            fan_q_reg <= MAG_W'(fan_recip_prod[MAG_W+RECIP_W-1:RECIP_SHIFT]);
        end
    end

    assign sts.div_done = div_done || fan_done_reg;
    assign quotient     = cmd.fan_phase ? fan_q_reg : div_quotient;

    // truncation toward zero: divide the magnitude, then restore the sign
    always_comb
    begin
        q_signed   = $signed({{(PROD_W + 1 - MAG_W){1'b0}}, quotient});
        if (prod_reg[PROD_W-1])
        begin
            q_signed = -q_signed;
        end
        interp_sum = $signed({{(PROD_W + 1 - LEVEL_W){1'b0}}, base}) + q_signed;
        if (interp_sum < 0)
        begin
            interp = '0;
        end
        else if (interp_sum > $signed({{(PROD_W + 1 - LEVEL_W){1'b0}}, LEVEL_MAX}))
        begin
            interp = LEVEL_MAX;
        end
        else
        begin
            interp = interp_sum[LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        case (sel_reg)
            ATOM_ZERO:   atom_new = '0;
            ATOM_MAX:    atom_new = atom_max_reg;
            ATOM_MIN:    atom_new = atom_min_reg;
            ATOM_INTERP: atom_new = interp;
            default:     atom_new = '0;
        endcase
    end

    assign atom_level_next = (abs_diff(atom_new, atom_level_reg) > DEADBAND_L)
                           ? atom_new : atom_level_reg;

    assign fan_off = (atom_level_reg == '0) && ((now_reg - last_active_reg) > OFF_DELAY_L);
    assign fan_new = fan_off ? '0 : interp;
    assign fan_level_next = (abs_diff(fan_new, fan_level_reg) > DEADBAND_L)
                          ? fan_new : fan_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_level_reg  <= '0;
            fan_level_reg   <= '0;
            last_active_reg <= '0;
            valve_reg       <= 1'b0;
            wl_reg          <= 1'b0;
            invalid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                wl_reg      <= in_data.water_low;
                valve_reg   <= in_data.water_low && (in_data.humidity_reading < desired_reg);
                invalid_reg <= invalid_in;
            end
            if (cmd.atom_apply)
            begin
                atom_level_reg <= atom_level_next;
                if (atom_new != '0)
                begin
                    last_active_reg <= now_reg;
                end
            end
            if (cmd.fan_apply)
            begin
                fan_level_reg <= fan_level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            h_reg   <= in_data.humidity_reading;
            now_reg <= in_data.now_ms;
            sel_reg <= sel_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (cmd.fan_apply)
        begin
            out_reg.valve_open      <= valve_reg;
            out_reg.atomizer_duty   <= atom_level_reg;
            out_reg.fan_duty        <= fan_level_next;
            out_reg.water_low_seen  <= wl_reg;
            out_reg.reading_invalid <= invalid_reg;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

### hw/rtl/hdc_ctrl.sv
// controller: sequences one beat through the datapath and owns the handshakes
`timescale 1ns / 1ps
`default_nettype none

module hdc_ctrl
    import hdc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output hdc_cmd_t      cmd,
    input  wire hdc_sts_t sts
);

    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_ATOM_MUL   = 9'b000000010,
        S_ATOM_GO    = 9'b000000100,
        S_ATOM_WAIT  = 9'b000001000,
        S_ATOM_APPLY = 9'b000010000,
        S_FAN_MUL    = 9'b000100000,
        S_FAN_GO     = 9'b001000000,
        S_FAN_WAIT   = 9'b010000000,
        S_FAN_APPLY  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ATOM_MUL;
                end
            end
            S_ATOM_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ATOM_GO;
            end
            S_ATOM_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_ATOM_WAIT;
            end
            S_ATOM_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_ATOM_APPLY;
                end
            end
            S_ATOM_APPLY:
            begin
                cmd.atom_apply = 1'b1;
                state_next     = S_FAN_MUL;
            end
            S_FAN_MUL:
            begin
                cmd.fan_phase = 1'b1;
                cmd.mul       = 1'b1;
                state_next    = S_FAN_GO;
            end
            S_FAN_GO:
            begin
                cmd.fan_phase = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_FAN_WAIT;
            end
            S_FAN_WAIT:
            begin
                cmd.fan_phase = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_FAN_APPLY;
                end
            end
            S_FAN_APPLY:
            begin
                cmd.fan_phase = 1'b1;
                if (slot_free)
                begin
                    cmd.fan_apply = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fan_apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fan_apply |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while a beat waits");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_ATOM_WAIT || state_reg == S_FAN_WAIT))
        else $error("divider finished outside a wait state");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat taken while one is in progress");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fan_apply |=> out_valid_reg)
        else $error("finished beat not presented");

endmodule

`default_nettype wire

### hw/rtl/humidifier_duty_controller_unit.sv
// top level of the humidifier duty controller
`timescale 1ns / 1ps
`default_nettype none

// Each input beat carries a humidity reading (tenths of a percent), the
// water-low sensor level and a millisecond timestamp; each one gives exactly
// one result beat with the valve drive, the applied atomizer and fan duties
// (per mille), the latched water-low state and an invalid-reading flag.
// Beats are handled one at a time: the atomizer multiply, divide and apply
// steps run, then the fan multiply, scale and apply steps, and the next beat
// can be taken as soon as the result is valid. Most of the time goes to a
// single restoring divider (one quotient bit per cycle, 20 bits) for the
// atomizer interpolation; the fan scaling by 1000 is a reciprocal multiply.
// A finished result sits in an output register, so a new beat may be taken
// while the previous result still waits; a result only stalls the block when
// the next one is ready and the first has still not been taken.
// Configuration writes are single-cycle with no read-back and must only be
// issued while the block is idle.

module humidifier_duty_controller_unit
    import hdc_pkg::*;
#(
    parameter int unsigned OFF_DELAY_MS = OFF_DELAY_MS_DEF,
    parameter int unsigned DEADBAND     = DEADBAND_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input beats
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire hdc_in_t              in_data,
    // result beats
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hdc_out_t                  out_data,
    // register writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    hdc_cmd_t cmd;
    hdc_sts_t sts;

    // sequencer: one beat walks atomizer multiply/divide/apply then fan
    hdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // registers, state, shared multiplier, atomizer divider, deadband and off-delay
    hdc_dp #(
        .OFF_DELAY_MS (OFF_DELAY_MS),
        .DEADBAND     (DEADBAND)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
